@@ rtl/core/sbr_pkg.sv @@
// sbr_pkg: shared types, register codes and an arithmetic helper for the
// separable 5-tap blur. Used by every module under rtl/core.
// No dependencies.
package sbr_pkg;

  localparam int CHANNELS  = 3;
  localparam int TAPS      = 5;
  localparam int LINE_ROWS = 4;

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;

  typedef struct packed {
    logic [7:0] chan_two;
    logic [7:0] chan_one;
    logic [7:0] chan_zero;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  out_zero;
    logic [7:0]  out_one;
    logic [7:0]  out_two;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        run_last;
  } pix_out_t;

  // load strobes and the hv select shared by the channel lanes
  typedef struct packed {
    logic iss_load;
    logic p1_load;
    logic hv_sel;
    logic p2_load;
  } sbr_ctl_t;

  // floor(s / 10) for s <= 2550 via reciprocal multiply
  function automatic logic [7:0] div10(input logic [11:0] s);
    logic [24:0] p;
    p = {13'd0, s} * 25'd6554;
    return p[23:16];
  endfunction

endpackage

@@ rtl/core/sbr_lane.sv @@
// sbr_lane: one color channel of the blur datapath, horizontal and
// vertical 1-2-4-2-1 sums with truncating divide by 10.
// Depends on sbr_pkg.
module sbr_lane import sbr_pkg::*; (
  input  logic                 clk_i,
  input  sbr_ctl_t             ctl_i,
  input  logic [TAPS-1:0][7:0] tap_i,
  input  logic [3:0][7:0]      line_i,
  output logic [7:0]           hv_o,
  output logic [7:0]           vert_o,
  output logic [7:0]           horiz_o
);

  logic [11:0] hsum_d, hsum_q;
  logic [7:0]  hv_d, hv_q;
  logic [11:0] vsum_d, vsum_q;
  logic [7:0]  hv2_q;

  assign hsum_d = {4'd0, tap_i[0]} + {3'd0, tap_i[1], 1'b0} + {2'd0, tap_i[2], 2'b0}
                + {3'd0, tap_i[3], 1'b0} + {4'd0, tap_i[4]};

  assign hv_d = ctl_i.hv_sel ? div10(hsum_q) : 8'd0;

  assign vsum_d = {4'd0, line_i[0]} + {3'd0, line_i[1], 1'b0} + {2'd0, line_i[2], 2'b0}
                + {3'd0, line_i[3], 1'b0} + {4'd0, hv_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.iss_load) begin
      hsum_q <= hsum_d;
    end
    if (ctl_i.p1_load) begin
      hv_q <= hv_d;
    end
    if (ctl_i.p2_load) begin
      vsum_q <= vsum_d;
      hv2_q  <= hv_q;
    end
  end

  assign hv_o    = hv_q;
  assign vert_o  = div10(vsum_q);
  assign horiz_o = hv2_q;

endmodule

@@ rtl/core/sbr_lines.sv @@
// sbr_lines: four line stores of horizontal results, one bank per row slot,
// read at one column for all slots with registered data.
// Depends on sbr_pkg.
module sbr_lines import sbr_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  logic                            clk_i,
  input  logic                            wr_en_i,
  input  logic [1:0]                      wr_slot_i,
  input  logic [AW-1:0]                   wr_addr_i,
  input  logic [CHANNELS*8-1:0]           wr_data_i,
  input  logic                            rd_en_i,
  input  logic [AW-1:0]                   rd_addr_i,
  input  logic [1:0]                      rd_row_i,
  output logic [3:0][CHANNELS*8-1:0]      tap_o
);

  logic [CHANNELS*8-1:0] bank_rd [LINE_ROWS];
  logic [1:0]            rd_row_q;

  for (genvar b = 0; b < LINE_ROWS; b++) begin : g_bank
    logic [CHANNELS*8-1:0] mem [MAX_WIDTH];
    logic [CHANNELS*8-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (wr_en_i && (wr_slot_i == 2'(b))) begin
        mem[wr_addr_i] <= wr_data_i;
      end
      if (rd_en_i) begin
        rd_q <= mem[rd_addr_i];
      end
    end
    assign bank_rd[b] = rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_row_q <= rd_row_i;
    end
  end

  // tap k is row r-4+k, which sits in slot (r+k) mod 4
  for (genvar k = 0; k < 4; k++) begin : g_tap
    assign tap_o[k] = bank_rd[2'(rd_row_q + 2'(k))];
  end

endmodule

@@ rtl/core/separable_blur_5tap_rgb.sv @@
// separable_blur_5tap_rgb: top level of the 5x5 separable blur, with
// position tracking, job issue, per-channel lanes and output merge.
// Depends on sbr_pkg, sbr_lane, sbr_lines.
//
// Usage: pixels enter in raster order on in_valid_i/in_ready_o/in_data_i.
// Blurred pixels leave on out_valid_o/out_ready_i/out_data_o, each tagged
// with its row and column; run_last marks the final result of one input.
// Registers frame_width (index 0) and frame_height (index 1) are written on
// the cfg channel, which is always ready; write them only while idle.
// Each input from column 2 on issues one column job, the pixel that ends a
// row issues three; jobs go through issue, line read, vertical sum and the
// output register. Throughput is one pixel per clock inside a row while
// out_ready_i is high and each column yields one result; a row end holds the
// input while its jobs issue (one line-store read port, one column per cycle),
// and in the last two rows of a frame, from row 4 on, each column yields two
// results, one per clock. Reset clears counters, history and valids and loads
// 640x480; line stores are not cleared. A stalled receiver holds the output
// register and the pipeline backs up until in_ready_o drops; nothing is lost.
module separable_blur_5tap_rgb import sbr_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pix_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pix_out_t   out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
  localparam int CW = (AW + 1 > 10) ? AW + 1 : 10;

  // configuration
  logic [10:0] fwidth_q;
  logic [11:0] fheight_q;
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwidth_q  <= WIDTH_RESET;
      fheight_q <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  fwidth_q  <= cfg_data_i[10:0];
        CFG_FRAME_HEIGHT: fheight_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [WW-1:0] fw_ext, w_eff;
  logic [11:0]   h_eff;

  assign fw_ext = WW'(fwidth_q);
  always_comb begin
    if (fw_ext < WW'(5)) begin
      w_eff = WW'(5);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
  end
  assign h_eff = (fheight_q < 12'd5) ? 12'd5 : fheight_q;

  // input side: position, history, flags
  logic [11:0] row_q, row_d;
  logic [9:0]  col_q, col_d;
  logic [3:0][CHANNELS*8-1:0] recent_q;
  logic [CHANNELS*8-1:0] cur;
  logic [WW:0] x_ext;
  logic        row_end, has_job, hv_ok, vert_f, horiz_f;
  logic        in_xfer;

  assign cur     = in_data_i;
  assign x_ext   = (WW + 1)'(col_q);
  assign row_end = x_ext >= (WW + 1)'(w_eff - WW'(1));
  assign has_job = col_q >= 10'd2;
  assign hv_ok   = (col_q >= 10'd4) && (x_ext + (WW + 1)'(1) <= (WW + 1)'(w_eff));
  assign vert_f  = (row_q >= 12'd4) && (row_q <= h_eff - 12'd1);
  assign horiz_f = (row_q < 12'd2) || ({1'b0, row_q} + 13'd2 >= {1'b0, h_eff});

  always_comb begin
    row_d = row_q;
    col_d = col_q + 10'd1;
    if (row_end) begin
      col_d = 10'd0;
      row_d = (row_q >= h_eff - 12'd1) ? 12'd0 : row_q + 12'd1;
    end
  end

  // issue stage: one pixel's column jobs
  logic        iss_valid_q;
  logic [9:0]  iss_col_q;
  logic [1:0]  iss_last_q, iss_idx_q;
  logic [11:0] iss_row_q;
  logic        iss_hvok_q, iss_vert_q, iss_horiz_q;
  logic        iss_lastjob, issue;

  // line-read stage
  logic        p1_valid_q;
  logic [9:0]  p1_col_q;
  logic [11:0] p1_row_q;
  logic        p1_vert_q, p1_horiz_q, p1_last_q;

  // vertical-sum stage
  logic        p2_valid_q, p2_vdone_q;
  logic [9:0]  p2_col_q;
  logic [11:0] p2_row_q;
  logic        p2_vert_q, p2_horiz_q, p2_last_q;

  logic        out_valid_q;
  pix_out_t    out_q, out_d;

  logic out_take, need_v, need_h, emit, p2_done, p2_free, p1_free, p2_load;

  assign out_take = !out_valid_q || out_ready_i;
  assign need_v   = p2_valid_q && p2_vert_q && !p2_vdone_q;
  assign need_h   = p2_valid_q && p2_horiz_q;
  assign emit     = (need_v || need_h) && out_take;
  assign p2_done  = p2_valid_q &&
                    (!(need_v || need_h) || (out_take && !(need_v && need_h)));
  assign p2_free  = !p2_valid_q || p2_done;
  assign p1_free  = !p1_valid_q || p2_free;
  assign p2_load  = p1_valid_q && p2_free;

  assign iss_lastjob = iss_idx_q == iss_last_q;
  assign issue       = iss_valid_q && p1_free;
  assign in_ready_o  = !iss_valid_q || (issue && iss_lastjob);
  assign in_xfer     = in_valid_i && in_ready_o;

  logic [9:0] iss_c;
  assign iss_c = iss_col_q + 10'(iss_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      recent_q    <= '0;
      iss_valid_q <= 1'b0;
      iss_idx_q   <= '0;
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      p2_vdone_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        row_q    <= row_d;
        col_q    <= col_d;
        recent_q <= {recent_q[2:0], cur};
      end
      if (in_xfer) begin
        iss_valid_q <= has_job;
        iss_idx_q   <= '0;
      end else if (issue) begin
        if (iss_lastjob) begin
          iss_valid_q <= 1'b0;
        end
        iss_idx_q <= iss_idx_q + 2'd1;
      end
      if (p1_free) begin
        p1_valid_q <= issue;
      end
      if (p2_free) begin
        p2_valid_q <= p2_load;
      end
      if (p2_load) begin
        p2_vdone_q <= 1'b0;
      end else if (emit && need_v && need_h) begin
        p2_vdone_q <= 1'b1;
      end
      if (out_take) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      iss_col_q   <= col_q - 10'd2;
      iss_last_q  <= row_end ? 2'd2 : 2'd0;
      iss_row_q   <= row_q;
      iss_hvok_q  <= hv_ok;
      iss_vert_q  <= vert_f;
      iss_horiz_q <= horiz_f;
    end
    if (issue) begin
      p1_col_q   <= iss_c;
      p1_row_q   <= iss_row_q;
      p1_vert_q  <= iss_vert_q;
      p1_horiz_q <= iss_horiz_q;
      p1_last_q  <= iss_lastjob;
    end
    if (p2_load) begin
      p2_col_q   <= p1_col_q;
      p2_row_q   <= p1_row_q;
      p2_vert_q  <= p1_vert_q;
      p2_horiz_q <= p1_horiz_q;
      p2_last_q  <= p1_last_q;
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  // column to line-store address, folded once
  function automatic logic [AW-1:0] col_addr(input logic [9:0] c);
    logic [CW-1:0] ce;
    ce = CW'(c);
    if (ce >= CW'(MAX_WIDTH)) begin
      ce = ce - CW'(MAX_WIDTH);
    end
    return ce[AW-1:0];
  endfunction

  // lanes
  sbr_ctl_t ctl;
  assign ctl.iss_load = in_xfer;
  assign ctl.p1_load  = issue;
  assign ctl.hv_sel   = (iss_idx_q == 2'd0) && iss_hvok_q;
  assign ctl.p2_load  = p2_load;

  logic [3:0][CHANNELS*8-1:0] line_tap;
  logic [CHANNELS-1:0][7:0]   hv, vert, horiz;

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    logic [TAPS-1:0][7:0] taps;
    logic [3:0][7:0]      lt;
    assign taps[0] = recent_q[3][8*ch +: 8];
    assign taps[1] = recent_q[2][8*ch +: 8];
    assign taps[2] = recent_q[1][8*ch +: 8];
    assign taps[3] = recent_q[0][8*ch +: 8];
    assign taps[4] = cur[8*ch +: 8];
    for (genvar k = 0; k < 4; k++) begin : g_lt
      assign lt[k] = line_tap[k][8*ch +: 8];
    end
    sbr_lane u_lane (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .tap_i   (taps),
      .line_i  (lt),
      .hv_o    (hv[ch]),
      .vert_o  (vert[ch]),
      .horiz_o (horiz[ch])
    );
  end

  sbr_lines #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_lines (
    .clk_i     (clk_i),
    .wr_en_i   (p2_load),
    .wr_slot_i (p1_row_q[1:0]),
    .wr_addr_i (col_addr(p1_col_q)),
    .wr_data_i (hv),
    .rd_en_i   (issue),
    .rd_addr_i (col_addr(iss_c)),
    .rd_row_i  (iss_row_q[1:0]),
    .tap_o     (line_tap)
  );

  // merge lanes into one result
  always_comb begin
    out_d.out_col = p2_col_q;
    if (need_v) begin
      out_d.out_zero = vert[0];
      out_d.out_one  = vert[1];
      out_d.out_two  = vert[2];
      out_d.out_row  = p2_row_q - 12'd2;
      out_d.run_last = p2_last_q && !p2_horiz_q;
    end else begin
      out_d.out_zero = horiz[0];
      out_d.out_one  = horiz[1];
      out_d.out_two  = horiz[2];
      out_d.out_row  = p2_row_q;
      out_d.run_last = p2_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sim/separable_blur_5tap_rgb_tb.sv @@
// separable_blur_5tap_rgb_tb: self-checking bench for the 5-tap rgb blur,
// with a clocked driver and monitor and its own blur predictor.
// Depends on sbr_pkg and separable_blur_5tap_rgb.
`timescale 1ns / 100ps

module separable_blur_5tap_rgb_tb;
  import sbr_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd2;  // index with no register behind it
  localparam int LINE_DEPTH = 1024;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  pix_in_t    in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  pix_out_t   out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [11:0] cfg_data_i = '0;

  pix_in_t  pixel_queue[$];
  pix_out_t blurred_queue[$];
  int       mismatches = 0;

  // predictor state
  logic [10:0] width_reg = WIDTH_RESET;
  logic [11:0] height_reg = HEIGHT_RESET;
  logic [23:0] history[4];
  logic [23:0] hline[4][LINE_DEPTH];
  int          cur_row = 0;
  int          cur_col = 0;

  separable_blur_5tap_rgb i_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] chan(logic [23:0] p, int ch);
    return p[8*ch +: 8];
  endfunction

  function automatic void predict_blur(pix_in_t px);
    int w, h, r, x, first, last, c, ch, s;
    logic [23:0] cur, a, b, m, d;
    logic [23:0] win[5];
    logic [7:0] hv[3];
    logic [7:0] vv[3];
    pix_out_t res[$];
    pix_out_t o;
    bit row_end;
    w = width_reg < 5 ? 5 : width_reg;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    h = height_reg < 5 ? 5 : height_reg;
    r = cur_row;
    x = cur_col;
    cur = {px.chan_two, px.chan_one, px.chan_zero};
    win[0] = history[3];
    win[1] = history[2];
    win[2] = history[1];
    win[3] = history[0];
    win[4] = cur;
    row_end = x >= w - 1;
    first = x >= 2 ? x - 2 : x + 1;
    last = row_end ? x : (x >= 2 ? x - 2 : 0);
    if (x >= 2 || row_end) begin
      for (c = first; c <= last; c++) begin
        for (ch = 0; ch < 3; ch++) hv[ch] = '0;
        if (c + 2 == x && c >= 2 && c + 3 <= w) begin
          for (ch = 0; ch < 3; ch++) begin
            s = chan(win[0], ch) + 2 * chan(win[1], ch) + 4 * chan(win[2], ch)
                + 2 * chan(win[3], ch) + chan(win[4], ch);
            hv[ch] = 8'(s / 10);
          end
        end
        if (r >= 4 && r <= h - 1) begin
          a = hline[(r - 4) & 3][c % LINE_DEPTH];
          b = hline[(r - 3) & 3][c % LINE_DEPTH];
          m = hline[(r - 2) & 3][c % LINE_DEPTH];
          d = hline[(r - 1) & 3][c % LINE_DEPTH];
          for (ch = 0; ch < 3; ch++) begin
            s = chan(a, ch) + 2 * chan(b, ch) + 4 * chan(m, ch) + 2 * chan(d, ch) + hv[ch];
            vv[ch] = 8'(s / 10);
          end
          o = '{out_zero: vv[0], out_one: vv[1], out_two: vv[2],
                out_row: 12'(r - 2), out_col: 10'(c), run_last: 1'b0};
          res.insert(res.size(), o);
        end
        if (r < 2 || r + 2 >= h) begin
          o = '{out_zero: hv[0], out_one: hv[1], out_two: hv[2],
                out_row: 12'(r), out_col: 10'(c), run_last: 1'b0};
          res.insert(res.size(), o);
        end
        hline[r & 3][c % LINE_DEPTH] = {hv[2], hv[1], hv[0]};
      end
    end
    if (res.size() > 0) res[res.size() - 1].run_last = 1'b1;
    foreach (res[i]) blurred_queue.insert(blurred_queue.size(), res[i]);
    history[3] = history[2];
    history[2] = history[1];
    history[1] = history[0];
    history[0] = cur;
    if (row_end) begin
      cur_col = 0;
      cur_row = (r >= h - 1) ? 0 : r + 1;
    end else begin
      cur_col = x + 1;
    end
  endfunction

  task automatic report(string field, int got, int want);
    $display("%0t: mismatch on %s: got %0d expected %0d", $time, field, got, want);
    mismatches++;
  endtask

  // driver: bursts of transfers with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) predict_blur(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pixel_queue.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 60);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern redrawn as rx_cycle advances, one long hold-off
  // once a large batch of pixels is waiting
  int rx_cycle = 0;
  int rx_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 2);
      if (!hold_done && hold_left == 0 && pixel_queue.size() > 40) hold_left = 400;
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_done = 1'b1;
        out_ready_i <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= $urandom_range(0, 3) != 0;
          default: out_ready_i <= $urandom_range(0, 3) == 0;
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pix_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (blurred_queue.size() == 0) begin
        report("unexpected transfer", out_data_o.out_col, -1);
      end else begin
        want = blurred_queue.pop_front();
        if (out_data_o.out_zero != want.out_zero)
          report("out_zero", out_data_o.out_zero, want.out_zero);
        if (out_data_o.out_one != want.out_one)
          report("out_one", out_data_o.out_one, want.out_one);
        if (out_data_o.out_two != want.out_two)
          report("out_two", out_data_o.out_two, want.out_two);
        if (out_data_o.out_row != want.out_row)
          report("out_row", out_data_o.out_row, want.out_row);
        if (out_data_o.out_col != want.out_col)
          report("out_col", out_data_o.out_col, want.out_col);
        if (out_data_o.run_last != want.run_last)
          report("run_last", out_data_o.run_last, want.run_last);
      end
    end
  end

  task automatic wait_idle();
    while (pixel_queue.size() > 0 || in_valid_i || blurred_queue.size() > 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    if (idx == CFG_FRAME_WIDTH) width_reg = data[10:0];
    else if (idx == CFG_FRAME_HEIGHT) height_reg = data;
    cfg_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
  endtask

  task automatic push_random(int count);
    pix_in_t p;
    repeat (count) begin
      p = pix_in_t'($urandom_range(0, 24'hffffff));
      pixel_queue.insert(pixel_queue.size(), p);
    end
  endtask

  task automatic frame_phase(logic [11:0] w, logic [11:0] h, int pixels);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    push_random(pixels);
    wait_idle();
  endtask

  initial begin
    foreach (history[i]) history[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: smallest frame with saturated, empty and checkered pixels
    write_reg(CFG_FRAME_WIDTH, 12'd5);
    write_reg(CFG_FRAME_HEIGHT, 12'd5);
    for (int i = 0; i < 25; i++) begin
      case (i % 5)
        0: pixel_queue.insert(pixel_queue.size(), '0);
        1: pixel_queue.insert(pixel_queue.size(), '1);
        2: pixel_queue.insert(pixel_queue.size(), 24'haa55aa);
        3: pixel_queue.insert(pixel_queue.size(), 24'h55aa55);
        default: push_random(1);
      endcase
    end
    wait_idle();

    write_reg(CFG_SPARE, 12'hfff);
    // values below the minimum clamp to 5
    frame_phase(12'd0, 12'd0, 25);
    frame_phase(12'd12, 12'd9, 108);
    frame_phase(12'd7, 12'd6, 42);
    // tallest frame, then shrink the height mid-frame so it wraps early
    frame_phase(12'd6, 12'd4095, 6 * 5);
    write_reg(CFG_FRAME_HEIGHT, 12'd4);
    push_random(6);
    wait_idle();
    frame_phase(12'd5, 12'd7, 35);

    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sbr_pkg.sv
rtl/core/sbr_lane.sv
rtl/core/sbr_lines.sv
rtl/core/separable_blur_5tap_rgb.sv
sim/separable_blur_5tap_rgb_tb.sv
